[design/assert_macros.svh]
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

[design/pps_pkg.sv]
// types, constants and helper functions for the palette scaler scan-out
package pps_pkg;

   localparam int IMG_WIDTH   = 160;
   localparam int IMG_HEIGHT  = 128;
   localparam int COLS_STRIDE = IMG_HEIGHT / 2;
   localparam int STORE_DEPTH = IMG_WIDTH * IMG_HEIGHT / 2;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int OUT_DEPTH   = 8;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

   localparam int RECIP_SHIFT = 17;
   localparam int RECIP_W     = 18;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [12:0] MAX_SCREEN = 13'd4096;

   // request codes
   localparam logic [1:0] REQ_PALETTE = 2'd0;
   localparam logic [1:0] REQ_IMAGE   = 2'd1;
   localparam logic [1:0] REQ_SCAN    = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR32  = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  palette_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [13:0] byte_address;
      logic [7:0]  byte_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] pixel_color;
      logic        end_of_line;
      logic        end_of_frame;
   } rsp_item_type;

   typedef struct packed {
      logic [4:0]  scale;
      logic [11:0] offset_x;
      logic [11:0] offset_y;
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic        color32;
   } cfg_type;

   // write payload carried down the pipe to the memory stages
   typedef struct packed {
      logic [3:0]  index;
      logic [31:0] color;
      logic [13:0] addr;
      logic [7:0]  value;
   } wr_type;

   // pipe contents after the quotient stage
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic        in_win;
      logic [11:0] col;
      logic [11:0] row;
      logic        eol;
      logic        eof;
      wr_type      wr;
   } pos_type;

   // ceil(2^17 / f); exact quotient for 12-bit dividends, zero acts as one
   function automatic logic [RECIP_W-1:0] recip(input logic [4:0] f);
      logic [RECIP_W-1:0] m;
      unique case (f)
         5'd0:    m = 18'd131072;
         5'd1:    m = 18'd131072;
         5'd2:    m = 18'd65536;
         5'd3:    m = 18'd43691;
         5'd4:    m = 18'd32768;
         5'd5:    m = 18'd26215;
         5'd6:    m = 18'd21846;
         5'd7:    m = 18'd18725;
         5'd8:    m = 18'd16384;
         5'd9:    m = 18'd14564;
         5'd10:   m = 18'd13108;
         5'd11:   m = 18'd11916;
         5'd12:   m = 18'd10923;
         5'd13:   m = 18'd10083;
         5'd14:   m = 18'd9363;
         5'd15:   m = 18'd8739;
         5'd16:   m = 18'd8192;
         5'd17:   m = 18'd7711;
         5'd18:   m = 18'd7282;
         5'd19:   m = 18'd6899;
         5'd20:   m = 18'd6554;
         5'd21:   m = 18'd6242;
         5'd22:   m = 18'd5958;
         5'd23:   m = 18'd5699;
         5'd24:   m = 18'd5462;
         5'd25:   m = 18'd5243;
         5'd26:   m = 18'd5042;
         5'd27:   m = 18'd4855;
         5'd28:   m = 18'd4682;
         5'd29:   m = 18'd4520;
         5'd30:   m = 18'd4370;
         default: m = 18'd4229;
      endcase
      return m;
   endfunction

   function automatic logic [12:0] clamp_dim(input logic [12:0] v);
      logic [12:0] r;
      if (v == 13'd0) begin
         r = 13'd1;
      end else if (v > MAX_SCREEN) begin
         r = MAX_SCREEN;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [31:0] convert_color(input logic c32, input logic [7:0] r,
                                                 input logic [7:0] g, input logic [7:0] b);
      logic [15:0] w16;
      w16 = {r[7:3], g[7:2], b[7:3]};
      return c32 ? {8'h00, r, g, b} : {w16, w16};
   endfunction

endpackage

[design/palette_scaler_scanout_top.sv]
// top level of the palette scaler scan-out block
// Scan-out of a 4-bit indexed image (160x128, column-major, two rows per byte)
// through a 16-entry palette, enlarged by an integer scale and placed at an
// offset on the screen. The block accepts one transfer of any request type per
// clock while fewer than eight scan ticks are outstanding, and each scan tick
// yields its pixel through the pipe: window test, reciprocal multiply for the
// divide by scale, frame store read, palette read, result queue. Image and
// palette writes are applied in the same pipe stage as the matching read, so
// a write is always seen by every later scan tick. The user must write
// registers through the csr port only while no request is in flight; the block
// does not enforce it. There is no clearing pass and unwritten memory entries
// read back as whatever they hold.
`include "assert_macros.svh"
module palette_scaler_scanout_top import pps_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_item_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_item_type           rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;

   // scan ticks accepted whose pixel has not been transferred yet
   logic [OUT_CNT_W-1:0] credit_ff, credit_in;

   logic         accept;
   logic         scan_accept;
   logic         rsp_xfer;
   logic         fifo_empty;
   logic         push;
   rsp_item_type push_data;
   pos_type      pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale         <= 5'd2;
         cfg_ff.offset_x      <= 12'd0;
         cfg_ff.offset_y      <= 12'd0;
         cfg_ff.screen_width  <= 13'd320;
         cfg_ff.screen_height <= 13'd256;
         cfg_ff.color32       <= 1'b1;
      end else if (csr_wr_en) begin
         // writes beyond the register list are dropped
         unique case (csr_index)
            CSR_SCALE:    cfg_ff.scale         <= csr_wdata[4:0];
            CSR_OFFSET_X: cfg_ff.offset_x      <= csr_wdata[11:0];
            CSR_OFFSET_Y: cfg_ff.offset_y      <= csr_wdata[11:0];
            CSR_WIDTH:    cfg_ff.screen_width  <= csr_wdata;
            CSR_HEIGHT:   cfg_ff.screen_height <= csr_wdata;
            CSR_COLOR32:  cfg_ff.color32       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // credit keeps the queue from overflowing without stalling the pipe
   assign req_ready   = credit_ff < OUT_CNT_W'(OUT_DEPTH);
   assign accept      = req_valid && req_ready;
   assign scan_accept = accept && req_data.req_type == REQ_SCAN;
   assign rsp_valid   = !fifo_empty;
   assign rsp_xfer    = rsp_valid && rsp_ready;

   always_comb begin
      credit_in = credit_ff;
      if (scan_accept && !rsp_xfer) begin
         credit_in = credit_ff + OUT_CNT_W'(1);
      end else if (rsp_xfer && !scan_accept) begin
         credit_in = credit_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // scan counters, window test and divide by scale
   pps_scan_ctrl u_scan_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .pos      (pos)
   );

   // frame store and palette lookups
   pps_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .pos       (pos),
      .push      (push),
      .push_data (push_data)
   );

   // results wait here for the response transfer
   pps_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_xfer),
      .empty     (fifo_empty),
      .pop_data  (rsp_data)
   );

   `ASSERT_ALWAYS(a_credit_bound, clock, reset, credit_ff <= OUT_CNT_W'(OUT_DEPTH))
   `ASSERT_IMPLY(a_rsp_has_credit, clock, reset, rsp_valid, credit_ff != '0)
   `ASSERT_IMPLY(a_eof_on_eol, clock, reset, rsp_valid && rsp_data.end_of_frame, rsp_data.end_of_line)

endmodule

[design/pps_scan_ctrl.sv]
// scan position, window offsets and quotient stages
module pps_scan_ctrl import pps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type req_data,
   input  cfg_type      cfg,
   output pos_type      pos
);

   logic [11:0] scan_col_ff, scan_col_in;
   logic [11:0] scan_row_ff, scan_row_in;

   logic               s1_valid_ff;
   logic [1:0]         s1_kind_ff;
   logic               s1_in_win_ff;
   logic [11:0]        s1_dx_ff, s1_dy_ff;
   logic [RECIP_W-1:0] s1_m_ff;
   logic               s1_eol_ff, s1_eof_ff;
   wr_type             s1_wr_ff;

   pos_type pos_ff;

   logic [12:0] w_last, h_last;
   logic        eol, eof;
   logic [29:0] prod_x, prod_y;
   wr_type      wr_in;

   always_comb begin
      w_last = clamp_dim(cfg.screen_width) - 13'd1;
      h_last = clamp_dim(cfg.screen_height) - 13'd1;
      eol    = {1'b0, scan_col_ff} >= w_last;
      eof    = eol && ({1'b0, scan_row_ff} >= h_last);
      scan_col_in = scan_col_ff;
      scan_row_in = scan_row_ff;
      if (accept && req_data.req_type == REQ_SCAN) begin
         if (eol) begin
            scan_col_in = 12'd0;
            scan_row_in = eof ? 12'd0 : scan_row_ff + 12'd1;
         end else begin
            scan_col_in = scan_col_ff + 12'd1;
         end
      end
      wr_in.index = req_data.palette_index;
      wr_in.color = convert_color(cfg.color32, req_data.red, req_data.green, req_data.blue);
      wr_in.addr  = req_data.byte_address;
      wr_in.value = req_data.byte_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff <= 12'd0;
         scan_row_ff <= 12'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         scan_col_ff <= scan_col_in;
         scan_row_ff <= scan_row_in;
         s1_valid_ff <= accept;
      end
   end

   // stage 1: window test and offset removal
   always_ff @(posedge clock) begin
      s1_kind_ff   <= req_data.req_type;
      s1_in_win_ff <= (scan_col_ff >= cfg.offset_x) && (scan_row_ff >= cfg.offset_y);
      s1_dx_ff     <= scan_col_ff - cfg.offset_x;
      s1_dy_ff     <= scan_row_ff - cfg.offset_y;
      s1_m_ff      <= recip(cfg.scale);
      s1_eol_ff    <= eol;
      s1_eof_ff    <= eof;
      s1_wr_ff     <= wr_in;
   end

   // stage 2: divide by scale through the reciprocal
   assign prod_x = 30'(s1_dx_ff) * 30'(s1_m_ff);
   assign prod_y = 30'(s1_dy_ff) * 30'(s1_m_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff.valid <= 1'b0;
      end else begin
         pos_ff.valid <= s1_valid_ff;
      end
      pos_ff.kind   <= s1_kind_ff;
      pos_ff.in_win <= s1_in_win_ff;
      pos_ff.col    <= prod_x[RECIP_SHIFT+11:RECIP_SHIFT];
      pos_ff.row    <= prod_y[RECIP_SHIFT+11:RECIP_SHIFT];
      pos_ff.eol    <= s1_eol_ff;
      pos_ff.eof    <= s1_eof_ff;
      pos_ff.wr     <= s1_wr_ff;
   end

   assign pos = pos_ff;

endmodule

[design/pps_fetch.sv]
// frame store and palette memories with their read stages
module pps_fetch import pps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pos_type      pos,
   output logic         push,
   output rsp_item_type push_data
);

   logic [7:0]  frame_mem [STORE_DEPTH];
   logic [31:0] pal_mem [16];

   logic        in_range;
   logic [23:0] addr_wide;
   logic [ADDR_W-1:0] rd_addr;
   logic        is_scan;
   logic [3:0]  nib;

   logic [7:0]  frame_rd_ff;
   logic        s3_scan_ff, s3_pal_wr_ff;
   logic        s3_in_range_ff, s3_row_lsb_ff, s3_eol_ff, s3_eof_ff;
   logic [3:0]  s3_index_ff;
   logic [31:0] s3_color_ff;

   logic [31:0] pal_rd_ff;
   logic        s4_scan_ff, s4_in_range_ff, s4_eol_ff, s4_eof_ff;

   always_comb begin
      is_scan   = pos.valid && pos.kind == REQ_SCAN;
      in_range  = pos.in_win && (32'(pos.col) < IMG_WIDTH) && (32'(pos.row) < IMG_HEIGHT);
      addr_wide = 24'(pos.col) * 24'(COLS_STRIDE) + 24'(pos.row[11:1]);
      rd_addr   = addr_wide[ADDR_W-1:0];
      nib       = s3_row_lsb_ff ? frame_rd_ff[7:4] : frame_rd_ff[3:0];
   end

   // frame store: image writes and scan reads share this stage, keeping order
   always_ff @(posedge clock) begin
      if (pos.valid && pos.kind == REQ_IMAGE && 32'(pos.wr.addr) < STORE_DEPTH) begin
         frame_mem[ADDR_W'(pos.wr.addr)] <= pos.wr.value;
      end
      if (is_scan && in_range) begin
         frame_rd_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_scan_ff   <= 1'b0;
         s3_pal_wr_ff <= 1'b0;
         s4_scan_ff   <= 1'b0;
      end else begin
         s3_scan_ff   <= is_scan;
         s3_pal_wr_ff <= pos.valid && pos.kind == REQ_PALETTE;
         s4_scan_ff   <= s3_scan_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_in_range_ff <= in_range;
      s3_row_lsb_ff  <= pos.row[0];
      s3_eol_ff      <= pos.eol;
      s3_eof_ff      <= pos.eof;
      s3_index_ff    <= pos.wr.index;
      s3_color_ff    <= pos.wr.color;
      s4_in_range_ff <= s3_in_range_ff;
      s4_eol_ff      <= s3_eol_ff;
      s4_eof_ff      <= s3_eof_ff;
   end

   // palette: writes and lookups share this stage
   always_ff @(posedge clock) begin
      if (s3_pal_wr_ff) begin
         pal_mem[s3_index_ff] <= s3_color_ff;
      end
      if (s3_scan_ff && s3_in_range_ff) begin
         pal_rd_ff <= pal_mem[nib];
      end
   end

   assign push                   = s4_scan_ff;
   assign push_data.pixel_color  = s4_in_range_ff ? pal_rd_ff : 32'd0;
   assign push_data.end_of_line  = s4_eol_ff;
   assign push_data.end_of_frame = s4_eof_ff;

endmodule

[design/pps_out_fifo.sv]
// result queue between the pipe and the response channel
`include "assert_macros.svh"
module pps_out_fifo import pps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_data,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type pop_data
);

   rsp_item_type         queue_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + OUT_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign empty    = count_ff == '0;
   assign pop_data = queue_ff[rd_ptr_ff];

   `ASSERT_IMPLY(a_no_overflow, clock, reset, push, count_ff < OUT_CNT_W'(OUT_DEPTH) || pop)
   `ASSERT_IMPLY(a_no_underflow, clock, reset, pop, count_ff != '0)
   `ASSERT_IMPLY(a_count_up, clock, reset, !$past(reset) && $past(push) && !$past(pop), count_ff == $past(count_ff) + OUT_CNT_W'(1))

endmodule
